@@ design/modified_miller_frame_decoder_defines.svh @@
// ----------------------------------------------------------------------------
// Modified Miller frame decoder assertion macros
// Shared wrappers for concurrent checks on clk / rst_n.
// ----------------------------------------------------------------------------
`ifndef MODIFIED_MILLER_FRAME_DECODER_DEFINES_SVH
`define MODIFIED_MILLER_FRAME_DECODER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define MMFD_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define MMFD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/mmfd_pkg.sv @@
// ----------------------------------------------------------------------------
// Modified Miller frame decoder package
// Payload types, configuration layout and shared codes.
// ----------------------------------------------------------------------------
package mmfd_pkg;

  // transaction types
  typedef struct packed {
    logic        req_type;
    logic [15:0] interval;
  } mmfd_in_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic       parity_expected;
    logic       parity_received;
    logic [2:0] status;
    logic [7:0] byte_count;
    logic       last_bit;
  } mmfd_out_t;

  typedef struct packed {
    logic [15:0] short_center;
    logic [15:0] medium_center;
    logic [15:0] long_center;
    logic [15:0] tolerance;
    logic [7:0]  max_bytes;
  } mmfd_cfg_t;

  // configuration register indexes
  localparam logic [2:0] CFG_SHORT_CENTER  = 3'd0;
  localparam logic [2:0] CFG_MEDIUM_CENTER = 3'd1;
  localparam logic [2:0] CFG_LONG_CENTER   = 3'd2;
  localparam logic [2:0] CFG_TOLERANCE     = 3'd3;
  localparam logic [2:0] CFG_MAX_BYTES     = 3'd4;

  localparam logic [15:0] SHORT_CENTER_RST  = 16'd90;
  localparam logic [15:0] MEDIUM_CENTER_RST = 16'd155;
  localparam logic [15:0] LONG_CENTER_RST   = 16'd220;
  localparam logic [15:0] TOLERANCE_RST     = 16'd20;
  localparam logic [7:0]  MAX_BYTES_RST     = 8'd20;

  // interval classes
  localparam logic [1:0] CLS_NONE   = 2'd0;
  localparam logic [1:0] CLS_SHORT  = 2'd1;
  localparam logic [1:0] CLS_MEDIUM = 2'd2;
  localparam logic [1:0] CLS_LONG   = 2'd3;

  // request / result kinds
  localparam logic REQ_INTERVAL   = 1'b0;
  localparam logic REQ_FRAME_END  = 1'b1;
  localparam logic KIND_BYTE      = 1'b0;
  localparam logic KIND_FRAME_END = 1'b1;

  // frame status codes
  localparam logic [2:0] ST_OK              = 3'd0;
  localparam logic [2:0] ST_SHORT           = 3'd1;
  localparam logic [2:0] ST_BAD_INTERVAL    = 3'd2;
  localparam logic [2:0] ST_BAD_START       = 3'd3;
  localparam logic [2:0] ST_LONG_AFTER_ZERO = 3'd4;
  localparam logic [2:0] ST_OVERFLOW        = 3'd5;
  localparam logic [2:0] ST_INCOMPLETE      = 3'd6;
  localparam logic [2:0] ST_EMPTY           = 3'd7;

  localparam logic [7:0] SHORT_FRAME_CODE = 8'h26;

endpackage

@@ design/mmfd_classify.sv @@
// ----------------------------------------------------------------------------
// Interval classifier
// Sorts one interval into short, medium, long or none by open windows.
// ----------------------------------------------------------------------------
module mmfd_classify (
  input  logic [15:0]        interval,
  input  mmfd_pkg::mmfd_cfg_t cfg,
  output logic [1:0]         cls
);
  import mmfd_pkg::*;

  logic hit_short;
  logic hit_medium;
  logic hit_long;

  function automatic logic in_window(logic [15:0] t, logic [15:0] c, logic [15:0] tol);
    logic [16:0] lo_sum;
    logic [16:0] hi_sum;
    lo_sum = {1'b0, t} + {1'b0, tol};
    hi_sum = {1'b0, c} + {1'b0, tol};
    return (lo_sum > {1'b0, c}) && ({1'b0, t} < hi_sum);
  endfunction

  assign hit_short  = in_window(interval, cfg.short_center,  cfg.tolerance);
  assign hit_medium = in_window(interval, cfg.medium_center, cfg.tolerance);
  assign hit_long   = in_window(interval, cfg.long_center,   cfg.tolerance);

  // short wins over medium wins over long
  always_comb begin
    if (hit_short) begin
      cls = CLS_SHORT;
    end else if (hit_medium) begin
      cls = CLS_MEDIUM;
    end else if (hit_long) begin
      cls = CLS_LONG;
    end else begin
      cls = CLS_NONE;
    end
  end

endmodule

@@ design/mmfd_frame.sv @@
// ----------------------------------------------------------------------------
// Frame state and Miller decode
// Holds the frame state, inserts decoded bits and builds result items.
// ----------------------------------------------------------------------------
`include "modified_miller_frame_decoder_defines.svh"

module mmfd_frame (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic                req_type,
  input  logic [1:0]          cls,
  input  logic [7:0]          max_bytes,
  output logic                res_vld,
  output mmfd_pkg::mmfd_out_t res
);
  import mmfd_pkg::*;

  typedef struct packed {
    logic [7:0] acc;
    logic [3:0] pos;
    logic       par;
    logic       prev;
    logic       last;
    logic [7:0] done;
    logic       await;
    logic [2:0] err;
  } frame_state_t;

  typedef struct packed {
    frame_state_t st;
    logic         emit;
    logic [7:0]   data;
    logic         pe;
    logic         pr;
  } ins_res_t;

  localparam frame_state_t FRAME_CLEAR = '{acc: 8'd0, pos: 4'd0, par: 1'b0, prev: 1'b0,
                                           last: 1'b0, done: 8'd0, await: 1'b1,
                                           err: ST_OK};

  frame_state_t st_r;
  frame_state_t st_nxt;
  frame_state_t base;
  frame_state_t after;
  ins_res_t     ins1;
  ins_res_t     ins2;
  logic [1:0]   ins_cnt;
  logic         bit0;
  logic         bit1;
  logic         chk_ovf;
  logic [2:0]   end_status;
  logic [7:0]   end_count;

  // one bit into the byte; ninth bit is the received parity
  function automatic ins_res_t insert(frame_state_t s, logic b);
    ins_res_t r;
    r      = '0;
    r.st   = s;
    if (s.pos < 4'd8) begin
      r.st.par = s.par ^ b;
      r.st.acc = s.acc | ({7'd0, b} << s.pos[2:0]);
      r.st.pos = s.pos + 4'd1;
    end else begin
      r.emit    = 1'b1;
      r.data    = s.acc;
      r.pe      = ~s.par;
      r.pr      = b;
      r.st.done = s.done + 8'd1;
      r.st.pos  = 4'd0;
      r.st.par  = 1'b0;
      r.st.acc  = 8'd0;
    end
    return r;
  endfunction

  // symbol decode: choose bits to insert and new prev/last
  always_comb begin
    base    = st_r;
    ins_cnt = 2'd0;
    bit0    = 1'b0;
    bit1    = 1'b0;
    chk_ovf = 1'b0;
    if (st_r.err == ST_OK) begin
      if (cls == CLS_NONE) begin
        base.err = ST_BAD_INTERVAL;
      end else if (st_r.await) begin
        base.await = 1'b0;
        if (cls == CLS_LONG) begin
          base.err = ST_BAD_START;
        end else begin
          chk_ovf = 1'b1;
          if (cls == CLS_MEDIUM) begin
            ins_cnt   = 2'd1;
            bit0      = 1'b1;
            base.prev = 1'b1;
            base.last = 1'b1;
          end
        end
      end else begin
        case (cls)
          CLS_SHORT: begin
            chk_ovf   = 1'b1;
            ins_cnt   = 2'd1;
            bit0      = st_r.prev;
            base.last = st_r.prev;
          end
          CLS_MEDIUM: begin
            chk_ovf = 1'b1;
            bit0    = 1'b0;
            bit1    = 1'b1;
            ins_cnt = st_r.prev ? 2'd1 : 2'd2;
            base.prev = ~st_r.prev;
            base.last = ~st_r.prev;
          end
          CLS_LONG: begin
            if (!st_r.prev) begin
              base.err = ST_LONG_AFTER_ZERO;
            end else begin
              chk_ovf   = 1'b1;
              ins_cnt   = 2'd2;
              bit0      = 1'b0;
              bit1      = 1'b1;
              base.prev = 1'b1;
              base.last = 1'b1;
            end
          end
          default: begin
            base.err = ST_BAD_INTERVAL;
          end
        endcase
      end
    end
  end

  assign ins1 = insert(base, bit0);
  assign ins2 = insert(ins1.st, bit1);

  always_comb begin
    case (ins_cnt)
      2'd1:    after = ins1.st;
      2'd2:    after = ins2.st;
      default: after = base;
    endcase
    if (chk_ovf && (after.done >= max_bytes)) begin
      after.err = ST_OVERFLOW;
    end
  end

  // frame-end status
  always_comb begin
    end_count = st_r.done;
    if (st_r.err != ST_OK) begin
      end_status = st_r.err;
    end else if (st_r.await) begin
      end_status = ST_EMPTY;
    end else if (st_r.pos == 4'd0) begin
      end_status = ST_OK;
    end else if ((st_r.pos == 4'd7) && (st_r.done == 8'd0) &&
                 (st_r.acc == SHORT_FRAME_CODE)) begin
      end_status = ST_SHORT;
      end_count  = 8'd1;
    end else begin
      end_status = ST_INCOMPLETE;
    end
  end

  always_comb begin
    st_nxt  = st_r;
    res_vld = 1'b0;
    res     = '0;
    if (step) begin
      if (req_type == REQ_FRAME_END) begin
        st_nxt         = FRAME_CLEAR;
        res_vld        = 1'b1;
        res.kind       = KIND_FRAME_END;
        res.data_byte  = st_r.acc;
        res.status     = end_status;
        res.byte_count = end_count;
        res.last_bit   = st_r.last;
      end else begin
        st_nxt   = after;
        res.kind = KIND_BYTE;
        if ((ins_cnt != 2'd0) && ins1.emit) begin
          res_vld             = 1'b1;
          res.data_byte       = ins1.data;
          res.parity_expected = ins1.pe;
          res.parity_received = ins1.pr;
        end else if ((ins_cnt == 2'd2) && ins2.emit) begin
          res_vld             = 1'b1;
          res.data_byte       = ins2.data;
          res.parity_expected = ins2.pe;
          res.parity_received = ins2.pr;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= FRAME_CLEAR;
    end else begin
      st_r <= st_nxt;
    end
  end

  `MMFD_ASSERT_IMPLY(a_end_always_reports, step && (req_type == REQ_FRAME_END), res_vld, "frame end gave no result")
  `MMFD_ASSERT_IMPLY(a_latched_silent, step && (req_type == REQ_INTERVAL) && (st_r.err != ST_OK), !res_vld && (st_nxt == st_r), "interval acted after latched error")
  `MMFD_ASSERT_NEXT(a_end_clears, step && (req_type == REQ_FRAME_END), st_r.await && (st_r.err == ST_OK) && (st_r.done == 8'd0) && (st_r.pos == 4'd0), "frame state not cleared after frame end")
  `MMFD_ASSERT_IMPLY(a_pos_range, 1'b1, st_r.pos <= 4'd8, "bit position out of range")

endmodule

@@ design/modified_miller_frame_decoder.sv @@
// ----------------------------------------------------------------------------
// Modified Miller frame decoder
// Reader-to-card 106 kbit interval decoder with byte and frame-end results.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_ready/in_data): one transaction is either a
//    measured pause-to-pause interval or a frame-end marker.
//  - Output channel (out_valid/out_ready/out_data): a completed byte with its
//    computed and received parity, or the frame-end status with byte count,
//    last data bit and partial byte. An interval yields zero or one result; a
//    frame end always yields exactly one.
//  - Config port (cfg_we/cfg_index/cfg_wdata): single-cycle writes of the
//    class centers, tolerance and overflow byte limit; write only while idle.
//  - Path: an accepted transaction is held in the input register; when the
//    input stage advances, its result is written to the output register and
//    out_valid rises, unless it was an interval with no result.
//  - Throughput: one transaction per cycle when not stalled; classify and
//    decode are one combinational pass between input and output registers.
//  - Stall: while out_ready is low the output register holds; the input
//    register still takes one more transaction, then in_ready drops.
//  - Reset: clears both pipeline valids and the frame state (awaiting the
//    first interval, no error); config registers return to defaults.
// ----------------------------------------------------------------------------
module modified_miller_frame_decoder (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mmfd_pkg::mmfd_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output mmfd_pkg::mmfd_out_t out_data,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_wdata
);
  import mmfd_pkg::*;

  mmfd_cfg_t  cfg_r;
  logic       s1_vld_r;
  mmfd_in_t   s1_data_r;
  logic       s1_adv;
  logic [1:0] cls;
  logic       res_vld;
  mmfd_out_t  res;
  logic       out_vld_r;
  mmfd_out_t  out_data_r;

  // config registers; out-of-range indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.short_center  <= SHORT_CENTER_RST;
      cfg_r.medium_center <= MEDIUM_CENTER_RST;
      cfg_r.long_center   <= LONG_CENTER_RST;
      cfg_r.tolerance     <= TOLERANCE_RST;
      cfg_r.max_bytes     <= MAX_BYTES_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SHORT_CENTER:  cfg_r.short_center  <= cfg_wdata;
        CFG_MEDIUM_CENTER: cfg_r.medium_center <= cfg_wdata;
        CFG_LONG_CENTER:   cfg_r.long_center   <= cfg_wdata;
        CFG_TOLERANCE:     cfg_r.tolerance     <= cfg_wdata;
        CFG_MAX_BYTES:     cfg_r.max_bytes     <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // input stage moves on when the output register is free or draining
  assign s1_adv   = s1_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !s1_vld_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_vld_r <= 1'b1;
    end else if (s1_adv) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
  end

  mmfd_classify u_classify (
    .interval (s1_data_r.interval),
    .cfg      (cfg_r),
    .cls      (cls)
  );

  // frame state advances exactly once per transaction leaving the input stage
  mmfd_frame u_frame (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (s1_adv),
    .req_type  (s1_data_r.req_type),
    .cls       (cls),
    .max_bytes (cfg_r.max_bytes),
    .res_vld   (res_vld),
    .res       (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_adv && res_vld) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && res_vld) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

endmodule

@@ sim/modified_miller_frame_decoder_tb.sv @@
// ----------------------------------------------------------------------------
// Modified Miller frame decoder testbench
// Drives interval and frame-end transactions through the decoder under
// several class window settings. A short directed table comes first, then
// random frames and noise. Results are checked field by field against typed
// rows or an in-bench model of Miller decode, byte packing, frame status.
// ----------------------------------------------------------------------------
module modified_miller_frame_decoder_tb;
  import mmfd_pkg::*;

  // clock, reset, DUT ports
  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  mmfd_in_t    in_data;
  logic        out_valid;
  logic        out_ready = 1'b0;
  mmfd_out_t   out_data;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_wdata;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  modified_miller_frame_decoder DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // --------------------------------------------------------------------------
  // Decode model: our own copy of the class windows and the frame state.
  // --------------------------------------------------------------------------
  logic [15:0] win_short, win_medium, win_long, win_tol;
  logic [7:0]  byte_limit;

  logic [7:0]  shift_acc;     // data bits collected so far, LSB first
  logic [3:0]  shift_pos;     // 0..8, position 8 takes the parity bit
  logic        shift_par;     // xor of the data bits
  logic        prev_val;      // Miller value the next interval refers to
  logic        last_val;      // last decoded data value of the frame
  logic [7:0]  frame_bytes;
  logic        sof_pending;   // next interval is the start of frame
  logic [2:0]  frame_err;     // first error of the frame, ST_OK if none

  mmfd_out_t   decoded_q[$];  // results still owed by the DUT

  function automatic void clear_frame();
    shift_acc   = '0;
    shift_pos   = '0;
    shift_par   = 1'b0;
    prev_val    = 1'b0;
    last_val    = 1'b0;
    frame_bytes = '0;
    sof_pending = 1'b1;
    frame_err   = ST_OK;
  endfunction

  // both window bounds exclusive; widened so the sums cannot wrap
  function automatic bit in_window(logic [15:0] t, logic [15:0] c);
    int unsigned ti, ci, tl;
    ti = t;
    ci = c;
    tl = win_tol;
    return (ti + tl > ci) && (ti < ci + tl);
  endfunction

  // classes are tried short first, then medium, then long
  function automatic logic [1:0] classify(logic [15:0] t);
    if (in_window(t, win_short))  return CLS_SHORT;
    if (in_window(t, win_medium)) return CLS_MEDIUM;
    if (in_window(t, win_long))   return CLS_LONG;
    return CLS_NONE;
  endfunction

  // Adds one decoded bit. The ninth bit closes the byte and fills res.
  function automatic bit shift_bit(input logic b, inout mmfd_out_t res);
    if (shift_pos < 4'd8) begin
      shift_par = shift_par ^ b;
      shift_acc = shift_acc | (8'(b) << shift_pos);
      shift_pos = shift_pos + 4'd1;
      return 1'b0;
    end
    res = '{kind: KIND_BYTE, data_byte: shift_acc, parity_expected: ~shift_par,
            parity_received: b, status: ST_OK, byte_count: 8'd0, last_bit: 1'b0};
    frame_bytes = frame_bytes + 8'd1;
    shift_pos   = '0;
    shift_par   = 1'b0;
    shift_acc   = '0;
    return 1'b1;
  endfunction

  // One accepted transaction; returns 1 when it owes a result.
  function automatic bit miller_decode(input mmfd_in_t it, output mmfd_out_t res);
    logic [2:0] st;
    logic [7:0] cnt;
    logic [1:0] cls;
    bit         got;
    res = '0;
    got = 1'b0;
    if (it.req_type == REQ_FRAME_END) begin
      cnt = frame_bytes;
      if (frame_err != ST_OK)   st = frame_err;
      else if (sof_pending)     st = ST_EMPTY;
      else if (shift_pos == 0)  st = ST_OK;
      else if (shift_pos == 4'd7 && frame_bytes == 0 && shift_acc == SHORT_FRAME_CODE) begin
        st  = ST_SHORT;
        cnt = 8'd1;
      end else                  st = ST_INCOMPLETE;
      res = '{kind: KIND_FRAME_END, data_byte: shift_acc, parity_expected: 1'b0,
              parity_received: 1'b0, status: st, byte_count: cnt, last_bit: last_val};
      clear_frame();
      return 1'b1;
    end

    // once an error is latched the rest of the frame is dropped
    if (frame_err != ST_OK) return 1'b0;
    cls = classify(it.interval);
    if (cls == CLS_NONE) begin
      frame_err = ST_BAD_INTERVAL;
      return 1'b0;
    end

    if (sof_pending) begin
      // start of frame: short is the plain start, medium carries a 1
      sof_pending = 1'b0;
      if (cls == CLS_LONG) begin
        frame_err = ST_BAD_START;
        return 1'b0;
      end
      if (cls == CLS_MEDIUM) begin
        got      = shift_bit(1'b1, res);
        prev_val = 1'b1;
        last_val = 1'b1;
      end
    end else if (cls == CLS_SHORT) begin
      got      = shift_bit(prev_val, res);
      last_val = prev_val;
    end else if (cls == CLS_MEDIUM) begin
      got = shift_bit(1'b0, res);
      if (!prev_val) begin
        got      = got | shift_bit(1'b1, res);
        prev_val = 1'b1;
        last_val = 1'b1;
      end else begin
        prev_val = 1'b0;
        last_val = 1'b0;
      end
    end else begin
      if (!prev_val) begin
        frame_err = ST_LONG_AFTER_ZERO;
        return 1'b0;
      end
      got      = shift_bit(1'b0, res);
      got      = got | shift_bit(1'b1, res);
      prev_val = 1'b1;
      last_val = 1'b1;
    end

    // limit is checked after every decoded interval, zero included
    if (frame_bytes >= byte_limit) frame_err = ST_OVERFLOW;
    return got;
  endfunction

  // --------------------------------------------------------------------------
  // Result checking and error reporting
  // --------------------------------------------------------------------------
  int err_count      = 0;
  int results_seen   = 0;
  int bytes_seen     = 0;
  int status_seen[8] = '{default: 0};

  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= 40) $display("ERROR @%0t result %0d: %s", $time, results_seen, msg);
  endtask

  task automatic check_result(input mmfd_out_t got);
    mmfd_out_t exp;
    if (decoded_q.size() == 0) begin
      report_mismatch($sformatf("unexpected result %h", got));
      return;
    end
    exp = decoded_q.pop_front();
    if (got.kind !== exp.kind)
      report_mismatch($sformatf("kind got %0h exp %0h", got.kind, exp.kind));
    if (got.data_byte !== exp.data_byte)
      report_mismatch($sformatf("data_byte got %0h exp %0h", got.data_byte, exp.data_byte));
    if (got.parity_expected !== exp.parity_expected)
      report_mismatch($sformatf("parity_expected got %0h exp %0h",
                                got.parity_expected, exp.parity_expected));
    if (got.parity_received !== exp.parity_received)
      report_mismatch($sformatf("parity_received got %0h exp %0h",
                                got.parity_received, exp.parity_received));
    if (got.status !== exp.status)
      report_mismatch($sformatf("status got %0h exp %0h", got.status, exp.status));
    if (got.byte_count !== exp.byte_count)
      report_mismatch($sformatf("byte_count got %0h exp %0h", got.byte_count, exp.byte_count));
    if (got.last_bit !== exp.last_bit)
      report_mismatch($sformatf("last_bit got %0h exp %0h", got.last_bit, exp.last_bit));
    if (exp.kind == KIND_FRAME_END) status_seen[exp.status]++;
    else bytes_seen++;
    results_seen++;
  endtask

  // --------------------------------------------------------------------------
  // Receiver: checks each output transaction, then picks out_ready for the
  // next cycle. The stall pattern switches at random intervals between
  // always ready, coin flip, 3-of-4 duty and occasional long stalls.
  // --------------------------------------------------------------------------
  int rx_mode      = 0;
  int rx_mode_left = 0;
  int rx_stall     = 0;
  int rx_cycle     = 0;

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) check_result(out_data);
    rx_cycle++;
    if (rx_mode_left == 0) begin
      rx_mode      = $urandom_range(0, 3);
      rx_mode_left = $urandom_range(50, 300);
    end
    rx_mode_left--;
    case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= (rx_cycle % 4) != 3;
      default: begin
        if (rx_stall > 0) begin
          rx_stall--;
          out_ready <= 1'b0;
        end else if ($urandom_range(0, 9) == 0) begin
          rx_stall = $urandom_range(3, 8);
          out_ready <= 1'b0;
        end else begin
          out_ready <= 1'b1;
        end
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Sender: one transaction per call. Bursts of back-to-back transactions are
  // separated by random gaps; now and then a long burst runs with no gaps.
  // in_valid stays high across a burst, so the next call only updates data.
  // --------------------------------------------------------------------------
  int items_sent = 0;
  int frames_sent = 0;
  int burst_left = 0;

  task automatic send_item(input mmfd_in_t it, input bit typed, input mmfd_out_t typed_res);
    mmfd_out_t res;
    bit        got;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    // accepted at this edge
    got = miller_decode(it, res);
    if (typed) begin
      got = 1'b1;
      res = typed_res;
    end
    if (got) decoded_q.push_back(res);
    items_sent++;
    if (it.req_type == REQ_FRAME_END) frames_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(0, 15);
    end
  endtask

  // Hold off until every owed result is back, plus the pipeline depth so an
  // interval with no result has also left the DUT.
  task automatic settle();
    in_valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_SHORT_CENTER:  win_short  = val;
      CFG_MEDIUM_CENTER: win_medium = val;
      CFG_LONG_CENTER:   win_long   = val;
      CFG_TOLERANCE:     win_tol    = val;
      CFG_MAX_BYTES:     byte_limit = val[7:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input int unsigned s, input int unsigned m, input int unsigned l,
                            input int unsigned t, input int unsigned mb);
    write_reg(CFG_SHORT_CENTER, 16'(s));
    write_reg(CFG_MEDIUM_CENTER, 16'(m));
    write_reg(CFG_LONG_CENTER, 16'(l));
    write_reg(CFG_TOLERANCE, 16'(t));
    write_reg(CFG_MAX_BYTES, 16'(mb));
    cfg_we <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Stimulus generation
  // --------------------------------------------------------------------------

  // An interval inside the window of one class, often right at its edge.
  // With zero tolerance no window exists, so any value will do.
  function automatic logic [15:0] interval_for(input logic [1:0] cls);
    int c, off, lim, v;
    case (cls)
      CLS_SHORT:  c = win_short;
      CLS_MEDIUM: c = win_medium;
      default:    c = win_long;
    endcase
    if (win_tol == 16'd0) return 16'($urandom);
    lim = (win_tol > 16'd200) ? 199 : int'(win_tol) - 1;
    if ($urandom_range(0, 4) == 0) off = int'(win_tol) - 1;
    else off = $urandom_range(0, lim);
    v = ($urandom_range(0, 1) != 0) ? c + off : c - off;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return 16'(v);
  endfunction

  // One frame and its frame end. Most frames follow legal Miller rules with
  // random content; a few carry glitches, bad starts or a long after a zero,
  // and some replay the 7-bit short frame command with jittered intervals.
  task automatic send_frame();
    int         n, r;
    logic       gp;
    logic [1:0] cls;
    logic [1:0] short_cmd[6];
    mmfd_in_t   it;
    short_cmd = '{CLS_SHORT, CLS_MEDIUM, CLS_SHORT, CLS_MEDIUM, CLS_MEDIUM, CLS_MEDIUM};
    it.req_type = REQ_INTERVAL;
    r = $urandom_range(0, 99);
    if (r < 6) begin
      foreach (short_cmd[k]) begin
        it.interval = interval_for(short_cmd[k]);
        send_item(it, 1'b0, '0);
      end
    end else begin
      n  = (r < 10) ? 0 : (r < 75) ? $urandom_range(1, 24) : $urandom_range(25, 70);
      gp = 1'b0;
      for (int k = 0; k < n; k++) begin
        r = $urandom_range(0, 99);
        if (r < 2) begin
          it.interval = 16'($urandom);  // glitch: anything at all
        end else begin
          if (k == 0) cls = (r < 5) ? CLS_LONG : (r < 75) ? CLS_SHORT : CLS_MEDIUM;
          else if (r < 4) cls = CLS_LONG;  // may land after a zero
          else if (gp) cls = 2'($urandom_range(1, 3));
          else cls = 2'($urandom_range(1, 2));
          // track the Miller value the way a legal encoder would
          if (cls == CLS_MEDIUM) gp = ~gp;
          else if (cls == CLS_LONG) gp = 1'b1;
          it.interval = interval_for(cls);
        end
        send_item(it, 1'b0, '0);
      end
    end
    it.req_type = REQ_FRAME_END;
    it.interval = 16'($urandom);
    send_item(it, 1'b0, '0);
  endtask

  // --------------------------------------------------------------------------
  // Directed table: typed results only where they are plain to read.
  // --------------------------------------------------------------------------
  typedef struct {
    mmfd_in_t  item;
    bit        typed;
    mmfd_out_t res;
  } dir_row_t;

  dir_row_t dir_rows[$];

  function automatic mmfd_out_t frame_status(input logic [2:0] st, input logic [7:0] cnt,
                                             input logic [7:0] data, input logic lb);
    return '{kind: KIND_FRAME_END, data_byte: data, parity_expected: 1'b0,
             parity_received: 1'b0, status: st, byte_count: cnt, last_bit: lb};
  endfunction

  task automatic add_row(input logic rt, input logic [15:0] iv, input bit typed,
                         input mmfd_out_t res);
    dir_row_t row;
    row.item.req_type = rt;
    row.item.interval = iv;
    row.typed         = typed;
    row.res           = res;
    dir_rows.push_back(row);
  endtask

  // Configuration phases: centers, tolerance, byte limit, transactions.
  // Phase 7 draws a random, well spaced setting.
  localparam int NUM_PHASES = 9;
  int unsigned ph_short[NUM_PHASES]  = '{90,  100, 90,  90,  0,     65000, 100, 0, 30};
  int unsigned ph_medium[NUM_PHASES] = '{155, 300, 155, 155, 32768, 65300, 110, 0, 60};
  int unsigned ph_long[NUM_PHASES]   = '{220, 500, 220, 220, 65535, 65535, 120, 0, 90};
  int unsigned ph_tol[NUM_PHASES]    = '{20,  5,   20,  0,   65535, 100,   50,  0, 12};
  int unsigned ph_limit[NUM_PHASES]  = '{20,  1,   0,   20,  255,   255,   3,   0, 2};
  int          ph_items[NUM_PHASES]  = '{600, 200, 60,  60,  100,   150,   150, 400, 200};

  initial begin
    int        phase_start, r;
    int        s, m, l, t, mb;
    mmfd_in_t  it;

    // reset values of the model
    win_short  = SHORT_CENTER_RST;
    win_medium = MEDIUM_CENTER_RST;
    win_long   = LONG_CENTER_RST;
    win_tol    = TOLERANCE_RST;
    byte_limit = MAX_BYTES_RST;
    clear_frame();

    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, run at the reset settings
    add_row(REQ_FRAME_END, 16'h0000, 1'b1, frame_status(ST_EMPTY, 8'd0, 8'h00, 1'b0));
    add_row(REQ_INTERVAL,  16'h0000, 1'b0, '0);       // below every window
    add_row(REQ_INTERVAL,  16'hFFFF, 1'b0, '0);       // dropped, error latched
    add_row(REQ_FRAME_END, 16'hFFFF, 1'b1,
            frame_status(ST_BAD_INTERVAL, 8'd0, 8'h00, 1'b0));
    add_row(REQ_INTERVAL,  16'd220,  1'b0, '0);       // long as first interval
    add_row(REQ_FRAME_END, 16'd0,    1'b1, frame_status(ST_BAD_START, 8'd0, 8'h00, 1'b0));
    add_row(REQ_INTERVAL,  16'd90,   1'b0, '0);       // start of frame
    add_row(REQ_INTERVAL,  16'd90,   1'b0, '0);       // repeats the zero
    add_row(REQ_INTERVAL,  16'd220,  1'b0, '0);       // long after a zero
    add_row(REQ_FRAME_END, 16'd1,    1'b1,
            frame_status(ST_LONG_AFTER_ZERO, 8'd0, 8'h00, 1'b0));
    // 7-bit short frame command: S M S M M M decodes to 0x26
    add_row(REQ_INTERVAL,  16'd90,   1'b0, '0);
    add_row(REQ_INTERVAL,  16'd155,  1'b0, '0);
    add_row(REQ_INTERVAL,  16'd90,   1'b0, '0);
    add_row(REQ_INTERVAL,  16'd155,  1'b0, '0);
    add_row(REQ_INTERVAL,  16'd155,  1'b0, '0);
    add_row(REQ_INTERVAL,  16'd155,  1'b0, '0);
    add_row(REQ_FRAME_END, 16'd0,    1'b1,
            frame_status(ST_SHORT, 8'd1, SHORT_FRAME_CODE, 1'b0));
    // medium start, then window edges, then a value between windows
    add_row(REQ_INTERVAL,  16'd155,  1'b0, '0);
    add_row(REQ_INTERVAL,  16'd239,  1'b0, '0);
    add_row(REQ_INTERVAL,  16'd71,   1'b0, '0);
    add_row(REQ_INTERVAL,  16'd174,  1'b0, '0);
    add_row(REQ_INTERVAL,  16'd110,  1'b0, '0);
    add_row(REQ_FRAME_END, 16'd0,    1'b0, '0);
    foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].res);
    settle();

    // random part, one configuration per phase
    for (int p = 0; p < NUM_PHASES; p++) begin
      s  = ph_short[p];
      m  = ph_medium[p];
      l  = ph_long[p];
      t  = ph_tol[p];
      mb = ph_limit[p];
      if (p == 7) begin
        s  = $urandom_range(20, 200);
        m  = s + $urandom_range(40, 120);
        l  = m + $urandom_range(40, 120);
        t  = $urandom_range(1, 30);
        mb = $urandom_range(1, 255);
      end
      set_config(s, m, l, t, mb);
      phase_start = items_sent;
      while (items_sent - phase_start < ph_items[p]) begin
        r = $urandom_range(0, 99);
        if (r < 10) begin
          // noise: any request type, any interval
          it.req_type = 1'($urandom_range(0, 1));
          it.interval = 16'($urandom);
          send_item(it, 1'b0, '0);
        end else begin
          send_frame();
        end
        // occasional full drain in the middle of a phase
        if ($urandom_range(0, 99) == 0) settle();
      end
      settle();
    end

    $display("Summary: %0d transactions (%0d directed, %0d frame ends), %0d results, %0d phases",
             items_sent, dir_rows.size(), frames_sent, results_seen, NUM_PHASES + 1);
    $display("Summary: bytes %0d, status ok %0d short %0d bad %0d start %0d long %0d",
             bytes_seen, status_seen[ST_OK], status_seen[ST_SHORT],
             status_seen[ST_BAD_INTERVAL], status_seen[ST_BAD_START],
             status_seen[ST_LONG_AFTER_ZERO]);
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // run limit, well above the slowest legal run
  initial begin
    #3000000;
    $display("ERROR: timeout, %0d results outstanding", decoded_q.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+design
design/mmfd_pkg.sv
design/mmfd_classify.sv
design/mmfd_frame.sv
design/modified_miller_frame_decoder.sv
sim/modified_miller_frame_decoder_tb.sv
